// ----- rtl/pspwm_pkg.sv -----
package pspwm_pkg;

    // Field widths
    localparam int STEP_W   = 12;
    localparam int CH_W     = 4;
    localparam int PINS_W   = 16;
    localparam int OP_W     = 2;
    localparam int PROD_W   = CH_W + STEP_W;
    localparam int DIV_W    = PROD_W + 1;
    localparam int CNT_W    = $clog2(DIV_W + 1);
    localparam int CFG_IDX_W = 1;

    // Reset values of the configuration registers
    localparam logic [STEP_W-1:0] RESET_PERIOD = 12'd2000;
    localparam logic [STEP_W-1:0] RESET_DELAY  = 12'd20;
    localparam logic [STEP_W-1:0] MIN_PERIOD   = 12'd2;
    localparam int                HALF_PERIOD  = int'(RESET_PERIOD) / 2;

    // Item operation codes
    typedef enum logic [OP_W-1:0] {
        OP_TICK   = 2'd0,
        OP_DUTY   = 2'd1,
        OP_ENABLE = 2'd2
    } op_t;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DELAY  = 1'b1;

    // Controller to datapath commands
    typedef struct packed {
        logic load;         // latch duty operands and product
        logic tick;         // evaluate pins, advance counter, fill output
        logic set_enable;   // take enable_value
        logic rem_go;       // start a remainder
        logic rem_sel_end;  // 0: start offset, 1: end time
        logic store_start;  // keep the start remainder
        logic write;        // write the channel's window
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic out_free;     // output register can take a word this cycle
        logic ch_in_range;  // incoming channel exists
        logic rem_done;     // remainder result ready
    } status_t;

    // Reset window of channel i; values stay below twice the period, so one
    // compare and subtract wraps them
    function automatic logic [STEP_W-1:0] reset_start(input int i);
        int prod;
        prod = i * int'(RESET_DELAY);
        if (prod >= int'(RESET_PERIOD))
            prod = prod - int'(RESET_PERIOD);
        reset_start = STEP_W'(prod);
    endfunction

    function automatic logic [STEP_W-1:0] reset_end(input int i);
        int sum;
        sum = HALF_PERIOD + int'(reset_start(i));
        if (sum >= int'(RESET_PERIOD))
            sum = sum - int'(RESET_PERIOD);
        reset_end = STEP_W'(sum);
    endfunction

endpackage

// ----- rtl/pspwm_if.sv -----
interface pspwm_req_if;
    import pspwm_pkg::*;

    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     op;
    logic [CH_W-1:0]     channel;
    logic [STEP_W-1:0]   duty_steps;
    logic                enable_value;

    modport source (output valid, op, channel, duty_steps, enable_value, input ready);
    modport sink   (input valid, op, channel, duty_steps, enable_value, output ready);
endinterface

interface pspwm_rsp_if;
    import pspwm_pkg::*;

    logic                valid;
    logic                ready;
    logic [PINS_W-1:0]   pin_levels;
    logic [STEP_W-1:0]   step_index;

    modport source (output valid, pin_levels, step_index, input ready);
    modport sink   (input valid, pin_levels, step_index, output ready);
endinterface

// ----- rtl/pspwm_rem.sv -----
module pspwm_rem (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            go,
    input  logic [pspwm_pkg::DIV_W-1:0]     dividend,
    input  logic [pspwm_pkg::STEP_W-1:0]    divisor,
    output logic                            done,
    output logic [pspwm_pkg::STEP_W-1:0]    result
);
    import pspwm_pkg::*;

    logic                busy_reg,  busy_next;
    logic                done_reg,  done_next;
    logic [CNT_W-1:0]    cnt_reg,   cnt_next;
    logic [DIV_W-1:0]    num_reg,   num_next;
    logic [STEP_W-1:0]   rem_reg,   rem_next;
    logic [STEP_W:0]     shifted;
    logic [STEP_W:0]     diff;

    // One restoring step: bring in the next dividend bit, subtract if it fits
    assign shifted = {rem_reg, num_reg[DIV_W-1]};
    assign diff    = shifted - {1'b0, divisor};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        rem_next  = rem_reg;
        if (go)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIV_W);
            num_next  = dividend;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            num_next = {num_reg[DIV_W-2:0], 1'b0};
            rem_next = (shifted >= {1'b0, divisor}) ? diff[STEP_W-1:0]
                                                    : shifted[STEP_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
    end

    assign done   = done_reg;
    assign result = rem_reg;

    // Remainder always lands below the divisor
    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (rem_reg < divisor))
        else $error("remainder not below divisor");

endmodule

// ----- rtl/pspwm_datapath.sv -----
module pspwm_datapath #(
    parameter int CHANNELS = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  pspwm_pkg::cmd_t                  cmd,
    output pspwm_pkg::status_t               status,
    // configuration writes
    input  logic                             cfg_we,
    input  logic [pspwm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pspwm_pkg::STEP_W-1:0]     cfg_data,
    // incoming word fields
    input  logic [pspwm_pkg::CH_W-1:0]       channel,
    input  logic [pspwm_pkg::STEP_W-1:0]     duty_steps,
    input  logic                             enable_value,
    // outgoing word
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [pspwm_pkg::PINS_W-1:0]     pin_levels,
    output logic [pspwm_pkg::STEP_W-1:0]     step_index
);
    import pspwm_pkg::*;

    logic [STEP_W-1:0]   period_reg;
    logic [STEP_W-1:0]   delay_reg;
    logic                enabled_reg;
    logic [STEP_W-1:0]   step_reg,  step_next;
    logic [STEP_W-1:0]   start_reg [CHANNELS];
    logic [STEP_W-1:0]   end_reg   [CHANNELS];
    logic [CH_W-1:0]     ch_reg;
    logic [STEP_W-1:0]   pw_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [STEP_W-1:0]   start_val_reg;
    logic                out_valid_reg;
    logic [PINS_W-1:0]   pins_reg;
    logic [STEP_W-1:0]   index_reg;

    logic [STEP_W-1:0]   per;
    logic [STEP_W-1:0]   s_cur;
    logic [STEP_W:0]     s_inc;
    logic [PINS_W-1:0]   pattern;
    logic [DIV_W-1:0]    rem_dividend;
    logic                rem_done;
    logic [STEP_W-1:0]   rem_result;

    // Effective period, never below two
    assign per = (period_reg < MIN_PERIOD) ? MIN_PERIOD : period_reg;

    // Counter left beyond a shortened period restarts at zero
    assign s_cur = (step_reg >= per) ? '0 : step_reg;
    assign s_inc = {1'b0, s_cur} + 1'b1;

    always_comb
    begin
        step_next = s_cur;
        if (enabled_reg)
            step_next = (s_inc == {1'b0, per}) ? '0 : s_inc[STEP_W-1:0];
    end

    // Window compare on every channel
    always_comb
    begin
        pattern = '0;
        for (int i = 0; i < CHANNELS; i++)
        begin
            if (start_reg[i] <= end_reg[i])
                pattern[i] = (s_cur >= start_reg[i]) && (s_cur < end_reg[i]);
            else
                pattern[i] = (s_cur >= start_reg[i]) || (s_cur < end_reg[i]);
        end
        if (!enabled_reg)
            pattern = '0;
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= RESET_PERIOD;
            delay_reg  <= RESET_DELAY;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_PERIOD: period_reg <= cfg_data;
                CFG_DELAY:  delay_reg  <= cfg_data;
                default:    ;
            endcase
        end
    end

    // Counter, enable and channel windows
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg    <= '0;
            enabled_reg <= 1'b1;
            for (int i = 0; i < CHANNELS; i++)
            begin
                start_reg[i] <= reset_start(i);
                end_reg[i]   <= reset_end(i);
            end
        end
        else
        begin
            if (cmd.tick)
                step_reg <= step_next;
            if (cmd.set_enable)
                enabled_reg <= enable_value;
            if (cmd.write)
            begin
                for (int i = 0; i < CHANNELS; i++)
                begin
                    if (ch_reg == CH_W'(i))
                    begin
                        start_reg[i] <= start_val_reg;
                        end_reg[i]   <= rem_result;
                    end
                end
            end
        end
    end

    // Duty operands: channel offset product registered ahead of the remainder
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ch_reg   <= channel;
            pw_reg   <= duty_steps;
            prod_reg <= PROD_W'(channel) * PROD_W'(delay_reg);
        end
        if (cmd.store_start)
            start_val_reg <= rem_result;
    end

    assign rem_dividend = cmd.rem_sel_end ? ({1'b0, prod_reg} + DIV_W'(pw_reg))
                                          : {1'b0, prod_reg};

    pspwm_rem u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (cmd.rem_go),
        .dividend (rem_dividend),
        .divisor  (per),
        .done     (rem_done),
        .result   (rem_result)
    );

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.tick)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.tick)
        begin
            pins_reg  <= pattern;
            index_reg <= s_cur;
        end
    end

    assign out_valid  = out_valid_reg;
    assign pin_levels = pins_reg;
    assign step_index = index_reg;

    assign status.out_free    = !out_valid_reg || out_ready;
    assign status.ch_in_range = ({1'b0, channel} < (CH_W + 1)'(CHANNELS));
    assign status.rem_done    = rem_done;

    // A tick always leaves a word in the output register
    a_tick_fills: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.tick |=> out_valid_reg)
        else $error("tick did not fill output register");

    // A tick never overwrites a word not yet taken
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.tick |-> (!out_valid_reg || out_ready))
        else $error("output word overwritten");

endmodule

// ----- rtl/pspwm_ctrl.sv -----
module pspwm_ctrl (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    input  logic [pspwm_pkg::OP_W-1:0]     op,
    output logic                           req_ready,
    input  pspwm_pkg::status_t             status,
    output pspwm_pkg::cmd_t                cmd
);
    import pspwm_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LAUNCH,
        S_REM_START,
        S_REM_END
    } state_t;

    state_t state_reg, state_next;
    logic   accept;

    assign req_ready = (state_reg == S_IDLE) && status.out_free;
    assign accept    = req_valid && req_ready;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (op)
                        OP_TICK:   cmd.tick = 1'b1;
                        OP_ENABLE: cmd.set_enable = 1'b1;
                        OP_DUTY:
                        begin
                            if (status.ch_in_range)
                            begin
                                cmd.load   = 1'b1;
                                state_next = S_LAUNCH;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_LAUNCH:
            begin
                cmd.rem_go = 1'b1;
                state_next = S_REM_START;
            end
            S_REM_START:
            begin
                if (status.rem_done)
                begin
                    cmd.store_start = 1'b1;
                    cmd.rem_go      = 1'b1;
                    cmd.rem_sel_end = 1'b1;
                    state_next      = S_REM_END;
                end
            end
            S_REM_END:
            begin
                if (status.rem_done)
                begin
                    cmd.write  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // No word taken while a duty update runs
    a_busy_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !req_ready)
        else $error("ready raised while busy");

    // A window write only closes a duty update
    a_write_end: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.write |=> (state_reg == S_IDLE))
        else $error("write outside duty update end");

endmodule

// ----- rtl/phase_staggered_multichannel_pwm_top.sv -----
// Multichannel PWM with one shared step counter and per-channel phase offset.
// Channels: req (op, channel, duty_steps, enable_value) and rsp
// (pin_levels, step_index), both valid/ready; a word moves when both are high.
// Configuration: cfg_we with cfg_index 0 = period_steps, 1 = channel_delay;
// the user must write them only while the block is idle; the block does not enforce this.
// Tick: its result word sits in the output register the cycle after it is
// taken; ticks stream at one per cycle while rsp is ready.
// Enable and unused op words: no result word.
// Set duty: the bit-serial remainder unit computes start and end times modulo
// the period one after the other; req is not ready during that time.
// When rsp stalls, the finished word is held and req stays ready only for
// the cycle in which the pending word is taken.
// Reset: step counter 0, output enabled, period 2000, delay 20, channel i
// window starts at i*20 and lasts half a period. No clearing pass is needed.
module phase_staggered_multichannel_pwm_top #(
    parameter int CHANNELS = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    pspwm_req_if.sink                        req,
    pspwm_rsp_if.source                      rsp,
    input  logic                             cfg_we,
    input  logic [pspwm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pspwm_pkg::STEP_W-1:0]     cfg_data
);
    import pspwm_pkg::*;

    cmd_t    cmd;
    status_t status;

    pspwm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .op        (req.op),
        .req_ready (req.ready),
        .status    (status),
        .cmd       (cmd)
    );

    pspwm_datapath #(
        .CHANNELS (CHANNELS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .channel      (req.channel),
        .duty_steps   (req.duty_steps),
        .enable_value (req.enable_value),
        .out_valid    (rsp.valid),
        .out_ready    (rsp.ready),
        .pin_levels   (rsp.pin_levels),
        .step_index   (rsp.step_index)
    );

endmodule

// ----- test/pwm_pattern_checker.sv -----
`timescale 1ns / 100ps

// Watches the request and response channels and the register port, keeps its
// own copy of the PWM state and compares every returned word with the oldest
// predicted one.
module pwm_pattern_checker #(
    parameter int CHANNELS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    pspwm_req_if                            req,
    pspwm_rsp_if                            rsp,
    input  logic                            cfg_we,
    input  logic [pspwm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pspwm_pkg::STEP_W-1:0]    cfg_data,
    output int                              mismatches,
    output int                              pending
);
    import pspwm_pkg::*;

    typedef struct packed {
        logic [PINS_W-1:0] pins;
        logic [STEP_W-1:0] step;
    } pin_word_t;

    pin_word_t         pin_word_q[$];
    pin_word_t         want;

    // Shadow copy of registers and PWM state
    logic [STEP_W-1:0] period_r;
    logic [STEP_W-1:0] delay_r;
    logic [STEP_W-1:0] step_r;
    logic [STEP_W-1:0] win_start[CHANNELS];
    logic [STEP_W-1:0] win_end[CHANNELS];
    logic              running;

    // Period as used by the counter: anything below the minimum counts as it
    function automatic int active_period();
        return (period_r < MIN_PERIOD) ? int'(MIN_PERIOD) : int'(period_r);
    endfunction

    task automatic load_reset_state();
        int start;
        period_r = RESET_PERIOD;
        delay_r  = RESET_DELAY;
        step_r   = '0;
        running  = 1'b1;
        for (int i = 0; i < CHANNELS; i++)
        begin
            start        = (i * int'(RESET_DELAY)) % int'(RESET_PERIOD);
            win_start[i] = STEP_W'(start);
            win_end[i]   = STEP_W'((int'(RESET_PERIOD) / 2 + start) % int'(RESET_PERIOD));
        end
    endtask

    // Apply one accepted request word; a tick queues the pin word it must return
    task automatic advance_pwm(input logic [OP_W-1:0] op, input logic [CH_W-1:0] ch,
                               input logic [STEP_W-1:0] pw, input logic en);
        int                per;
        int                s;
        int                a;
        int                b;
        logic              hi;
        logic [PINS_W-1:0] pat;
        pin_word_t         w;
        per = active_period();
        case (op_t'(op))
            OP_TICK:
            begin
                // counter left over from a longer period restarts at zero
                if (int'(step_r) >= per)
                    step_r = '0;
                s   = int'(step_r);
                pat = '0;
                if (running)
                begin
                    for (int i = 0; i < CHANNELS; i++)
                    begin
                        a = int'(win_start[i]);
                        b = int'(win_end[i]);
                        if (a <= b)
                            hi = (s >= a) && (s < b);
                        else
                            hi = (s >= a) || (s < b);
                        pat[i] = hi;
                    end
                    step_r = STEP_W'((s + 1) % per);
                end
                w.pins = pat;
                w.step = STEP_W'(s);
                pin_word_q.push_back(w);
            end
            OP_DUTY:
            begin
                if (int'(ch) < CHANNELS)
                begin
                    win_start[ch] = STEP_W'((int'(ch) * int'(delay_r)) % per);
                    win_end[ch]   = STEP_W'((int'(pw) + int'(ch) * int'(delay_r)) % per);
                end
            end
            OP_ENABLE:
                running = en;
            default:
                ;
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_reset_state();
            pin_word_q.delete();
            mismatches = 0;
        end
        else
        begin
            // returned word against the oldest prediction
            if (rsp.valid && rsp.ready)
            begin
                if (pin_word_q.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected word pin_levels %h step_index %0d", $time,
                             rsp.pin_levels, rsp.step_index);
                end
                else
                begin
                    want = pin_word_q.pop_front();
                    if (rsp.pin_levels !== want.pins)
                    begin
                        mismatches++;
                        $display("%0t: pin_levels expected %h got %h", $time,
                                 want.pins, rsp.pin_levels);
                    end
                    if (rsp.step_index !== want.step)
                    begin
                        mismatches++;
                        $display("%0t: step_index expected %0d got %0d", $time,
                                 want.step, rsp.step_index);
                    end
                end
            end
            // register writes
            if (cfg_we)
            begin
                if (cfg_index == CFG_PERIOD)
                    period_r = cfg_data;
                else
                    delay_r = cfg_data;
            end
            if (req.valid && req.ready)
                advance_pwm(req.op, req.channel, req.duty_steps, req.enable_value);
        end
        pending = pin_word_q.size();
    end

endmodule

// ----- test/tb_phase_staggered_multichannel_pwm_top.sv -----
`timescale 1ns / 100ps

module tb_phase_staggered_multichannel_pwm_top;
    import pspwm_pkg::*;

    localparam int              CHANNELS        = 16;
    localparam logic [OP_W-1:0] OP_SPARE        = 2'd3;
    localparam int              MAX_WAIT        = 17;
    // set duty keeps the block busy without a word
    localparam int              SETTLE_CYCLES   = 40;
    localparam int              ITEMS_PER_PHASE = 40;
    localparam int              PHASES          = 9;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_PERIOD;
    logic [STEP_W-1:0]    cfg_data = '0;
    int                   mismatches;
    int                   pending;
    bit                   send_quiet = 1'b0;
    bit                   rsp_quiet = 1'b0;
    int                   cur_period = int'(RESET_PERIOD);

    pspwm_req_if req();
    pspwm_rsp_if rsp();

    phase_staggered_multichannel_pwm_top #(
        .CHANNELS (CHANNELS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    pwm_pattern_checker #(
        .CHANNELS (CHANNELS)
    ) u_pwm_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .rsp        (rsp),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .pending    (pending)
    );

    always #5 clk = ~clk;

    // One request word: optional idle gap, then hold until accepted
    task automatic send_word(input logic [OP_W-1:0] op, input logic [CH_W-1:0] ch,
                             input logic [STEP_W-1:0] pw, input logic en);
        int gap;
        gap = send_quiet ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0)
        begin
            req.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        req.valid        = 1'b1;
        req.op           = op;
        req.channel      = ch;
        req.duty_steps   = pw;
        req.enable_value = en;
        do
            @(posedge clk);
        while (!req.ready);
        @(negedge clk);
    endtask

    // Mostly ticks, some duty updates and enables, a few unused-op words
    task automatic send_random();
        int                pick;
        logic [OP_W-1:0]   op;
        logic [STEP_W-1:0] pw;
        pick = $urandom_range(0, 99);
        if (pick < 68)
            op = OP_TICK;
        else if (pick < 83)
            op = OP_DUTY;
        else if (pick < 95)
            op = OP_ENABLE;
        else
            op = OP_SPARE;
        if ($urandom_range(0, 2) == 0)
            pw = STEP_W'($urandom_range(0, 4095));
        else
            pw = STEP_W'($urandom_range(0, cur_period));
        send_word(op, CH_W'($urandom_range(0, CHANNELS - 1)), pw,
                  $urandom_range(0, 3) != 0);
    endtask

    // Wait for every predicted word, then let a duty update finish
    task automatic settle();
        req.valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic program_regs(input logic [STEP_W-1:0] period, input logic [STEP_W-1:0] delay);
        cfg_we    = 1'b1;
        cfg_index = CFG_PERIOD;
        cfg_data  = period;
        @(negedge clk);
        cfg_index = CFG_DELAY;
        cfg_data  = delay;
        @(negedge clk);
        cfg_we     = 1'b0;
        cur_period = (period < MIN_PERIOD) ? int'(MIN_PERIOD) : int'(period);
    endtask

    // Response side: random stall before each word, held ready until it moves
    initial
    begin
        int stall;
        rsp.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            stall = rsp_quiet ? 0 : $urandom_range(0, MAX_WAIT);
            if (stall > 0)
            begin
                rsp.ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            rsp.ready = 1'b1;
            do
                @(posedge clk);
            while (rsp.valid !== 1'b1);
        end
    end

    // Stimulus and verdict
    initial
    begin
        req.valid        = 1'b0;
        req.op           = OP_TICK;
        req.channel      = '0;
        req.duty_steps   = '0;
        req.enable_value = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset windows first
        send_word(OP_TICK, 4'd0, 12'd0, 1'b0);
        send_word(OP_TICK, 4'd15, 12'd4095, 1'b1);
        // empty window, oversized width, wrapping windows
        send_word(OP_DUTY, 4'd0, 12'd0, 1'b0);
        send_word(OP_DUTY, 4'd15, 12'd4095, 1'b1);
        send_word(OP_DUTY, 4'd14, 12'd1999, 1'b0);
        send_word(OP_DUTY, 4'd1, 12'd1980, 1'b1);
        send_word(OP_TICK, 4'd3, 12'd7, 1'b0);
        // disabled: pins low, counter held
        send_word(OP_ENABLE, 4'd0, 12'd0, 1'b0);
        send_word(OP_TICK, 4'd0, 12'd0, 1'b0);
        send_word(OP_TICK, 4'd9, 12'd100, 1'b1);
        send_word(OP_SPARE, 4'd15, 12'd4095, 1'b1);
        send_word(OP_TICK, 4'd0, 12'd0, 1'b0);
        send_word(OP_ENABLE, 4'd15, 12'd4095, 1'b1);
        send_word(OP_TICK, 4'd0, 12'd0, 1'b0);
        // width of a whole period gives an empty window
        send_word(OP_DUTY, 4'd7, 12'd2000, 1'b0);
        send_word(OP_TICK, 4'd0, 12'd0, 1'b0);
        send_word(OP_TICK, 4'd0, 12'd0, 1'b0);
        repeat (ITEMS_PER_PHASE) send_random();

        for (int phase = 0; phase < PHASES; phase++)
        begin
            settle();
            case (phase)
                0:       program_regs(12'd0, 12'd4095);
                1:       program_regs(12'd1, 12'd0);
                2:       program_regs(12'd2, 12'd1);
                3:       program_regs(12'd4095, 12'd4095);
                4:       program_regs(12'd7, 12'd3);
                default: program_regs(STEP_W'($urandom_range(3, 48)),
                                      STEP_W'($urandom_range(0, 4095)));
            endcase
            send_quiet = ($urandom_range(0, 3) == 0);
            rsp_quiet  = ($urandom_range(0, 3) == 0);
            repeat (ITEMS_PER_PHASE) send_random();
        end

        settle();
        if (mismatches == 0)
            $display("tb_phase_staggered_multichannel_pwm_top: clean");
        else
            $display("tb_phase_staggered_multichannel_pwm_top: errors");
        $finish;
    end

    // Watchdog
    initial
    begin
        #5_000_000;
        $display("tb_phase_staggered_multichannel_pwm_top: errors");
        $finish;
    end

endmodule

// ----- phase_staggered_multichannel_pwm_top.f -----
rtl/pspwm_pkg.sv
rtl/pspwm_if.sv
rtl/pspwm_rem.sv
rtl/pspwm_datapath.sv
rtl/pspwm_ctrl.sv
rtl/phase_staggered_multichannel_pwm_top.sv
test/pwm_pattern_checker.sv
test/tb_phase_staggered_multichannel_pwm_top.sv
